FILE: rtl/cbe_pkg.sv
// shared constants, types and width helpers of the cubic bezier evaluator
`default_nettype none

package cbe_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int T_FRAC_BITS_DEF = 16;

   localparam int POINT_WIDTH = 48;
   localparam int T_IN_WIDTH  = 18;
   localparam int OUT_WIDTH   = 20;
   localparam int NUM_AXES    = 3;
   localparam int NUM_POINTS  = 4;
   localparam int CHUNK_WIDTH = 32;
   localparam int NUM_STAGES  = 8;

   localparam int OUT_MAX = 524287;
   localparam int OUT_MIN = -524288;

   localparam logic MODE_POINT = 1'b0;
   localparam logic MODE_DERIV = 1'b1;

   // load enables of the pipeline stages, first stage first
   typedef struct packed {
      logic coef;
      logic mul1;
      logic add1;
      logic mul2;
      logic add2;
      logic mul3;
      logic add3;
      logic outp;
   } stage_en_type;

   // polynomial coefficients carry five bits above the coordinate
   function automatic int coef_width(input int cw);
      return cw + 5;
   endfunction

   // accumulator width after the given number of multiply-by-t steps
   function automatic int acc_width(input int cw, input int fb, input int steps);
      return cw + 5 + steps * (fb + 1);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cbe_req_if.sv
// request channel: control points, curve parameter and mode
`default_nettype none

interface cbe_req_if import cbe_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [POINT_WIDTH-1:0]       point_a;
   logic [POINT_WIDTH-1:0]       point_b;
   logic [POINT_WIDTH-1:0]       point_c;
   logic [POINT_WIDTH-1:0]       point_d;
   logic signed [T_IN_WIDTH-1:0] param_t;
   logic                         mode;

   modport source (output valid, output point_a, output point_b, output point_c,
                   output point_d, output param_t, output mode, input ready);
   modport sink (input valid, input point_a, input point_b, input point_c,
                 input point_d, input param_t, input mode, output ready);
endinterface

`default_nettype wire

FILE: rtl/cbe_rsp_if.sv
// response channel: evaluated point or derivative
`default_nettype none

interface cbe_rsp_if import cbe_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] out_x;
   logic signed [OUT_WIDTH-1:0] out_y;
   logic signed [OUT_WIDTH-1:0] out_z;

   modport source (output valid, output out_x, output out_y, output out_z, input ready);
   modport sink (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

`default_nettype wire

FILE: rtl/cbe_horner_step.sv
// one horner step: acc * t + coef * one^power, partial products then sum
`default_nettype none

module cbe_horner_step import cbe_pkg::*; #(
   parameter int ACC_IN_WIDTH = 21,
   parameter int T_FRAC_BITS  = T_FRAC_BITS_DEF,
   parameter int COEF_WIDTH   = 21,
   parameter int POWER        = 1
) (
   input  logic                                    clock,
   input  logic                                    en_mul,
   input  logic                                    en_add,
   input  logic signed [ACC_IN_WIDTH-1:0]          acc_src,
   input  logic [T_FRAC_BITS:0]                    t_src,
   input  logic signed [COEF_WIDTH-1:0]            coef_src,
   output logic signed [ACC_IN_WIDTH+T_FRAC_BITS:0] acc_res
);

   localparam int ACC_OUT_WIDTH = ACC_IN_WIDTH + T_FRAC_BITS + 1;
   localparam int NUM_CHUNKS    = (ACC_IN_WIDTH + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
   localparam int EXT_WIDTH     = NUM_CHUNKS * CHUNK_WIDTH;
   localparam int PP_WIDTH      = CHUNK_WIDTH + T_FRAC_BITS + 3;
   localparam int SHIFT         = POWER * T_FRAC_BITS;

   logic signed [EXT_WIDTH-1:0]     acc_ext;
   logic signed [T_FRAC_BITS+1:0]   t_op;
   logic signed [CHUNK_WIDTH:0]     op [NUM_CHUNKS];
   logic signed [PP_WIDTH-1:0]      pp_in [NUM_CHUNKS];
   logic signed [PP_WIDTH-1:0]      pp_ff [NUM_CHUNKS];
   logic signed [COEF_WIDTH-1:0]    coef_ff;
   logic signed [ACC_OUT_WIDTH-1:0] acc_in;
   logic signed [ACC_OUT_WIDTH-1:0] acc_ff;

   assign acc_ext = EXT_WIDTH'(acc_src);
   assign t_op    = $signed({1'b0, t_src});

   // 32-bit slices of the accumulator, only the top slice is signed
   always_comb begin
      for (int j = 0; j < NUM_CHUNKS; j++) begin
         if (j == NUM_CHUNKS - 1) begin
            op[j] = {acc_ext[EXT_WIDTH-1], acc_ext[j*CHUNK_WIDTH +: CHUNK_WIDTH]};
         end else begin
            op[j] = {1'b0, acc_ext[j*CHUNK_WIDTH +: CHUNK_WIDTH]};
         end
         pp_in[j] = op[j] * t_op;
      end
   end

   // exact sum, modulo the output width which holds the true value
   always_comb begin
      acc_in = ACC_OUT_WIDTH'(coef_ff) <<< SHIFT;
      for (int j = 0; j < NUM_CHUNKS; j++) begin
         acc_in = acc_in + (ACC_OUT_WIDTH'(pp_ff[j]) <<< (j * CHUNK_WIDTH));
      end
   end

   always_ff @(posedge clock) begin
      if (en_mul) begin
         pp_ff   <= pp_in;
         coef_ff <= coef_src;
      end
      if (en_add) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_res = acc_ff;

endmodule

`default_nettype wire

FILE: rtl/cbe_lane.sv
// one coordinate lane: power-basis coefficients and three horner steps
`default_nettype none

module cbe_lane import cbe_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  stage_en_type             stage_en,
   input  logic signed [COORD_WIDTH-1:0] p0,
   input  logic signed [COORD_WIDTH-1:0] p1,
   input  logic signed [COORD_WIDTH-1:0] p2,
   input  logic signed [COORD_WIDTH-1:0] p3,
   input  logic [T_FRAC_BITS:0]     t_val,
   input  logic                     mode,
   output logic signed [acc_width(COORD_WIDTH, T_FRAC_BITS, 3)-1:0] acc_res
);

   localparam int CW = coef_width(COORD_WIDTH);
   localparam int A1 = acc_width(COORD_WIDTH, T_FRAC_BITS, 1);
   localparam int A2 = acc_width(COORD_WIDTH, T_FRAC_BITS, 2);
   localparam int TW = T_FRAC_BITS + 1;

   logic signed [CW-1:0] d10, d21, d32, dd, c1, c2, c3;
   logic signed [CW-1:0] e0_in, e1_in, e2_in, e3_in;
   logic signed [CW-1:0] e0_ff, e1_ff, e2_ff, e3_ff;
   logic [TW-1:0]        t0_ff, t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [CW-1:0] e1_d1_ff, e1_d2_ff;
   logic signed [CW-1:0] e0_d1_ff, e0_d2_ff, e0_d3_ff, e0_d4_ff;
   logic signed [A1-1:0] acc1;
   logic signed [A2-1:0] acc2;

   // p(t) = p0 + c1 t + c2 t^2 + c3 t^3 with differences of neighbors
   always_comb begin
      d10 = CW'(p1) - CW'(p0);
      d21 = CW'(p2) - CW'(p1);
      d32 = CW'(p3) - CW'(p2);
      dd  = d21 - d10;
      c1  = d10 + (d10 <<< 1);
      c2  = dd + (dd <<< 1);
      c3  = d32 - (d21 <<< 1) + d10;
      case (mode)
         MODE_POINT: begin
            e0_in = CW'(p0);
            e1_in = c1;
            e2_in = c2;
            e3_in = c3;
         end
         MODE_DERIV: begin
            // derivative c1 + 2 c2 t + 3 c3 t^2, one power of one higher
            e0_in = c1;
            e1_in = c2 <<< 1;
            e2_in = c3 + (c3 <<< 1);
            e3_in = '0;
         end
         default: begin
            e0_in = '0;
            e1_in = '0;
            e2_in = '0;
            e3_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en.coef) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         e3_ff <= e3_in;
         t0_ff <= t_val;
      end
      if (stage_en.mul1) begin
         t1_ff    <= t0_ff;
         e1_d1_ff <= e1_ff;
         e0_d1_ff <= e0_ff;
      end
      if (stage_en.add1) begin
         t2_ff    <= t1_ff;
         e1_d2_ff <= e1_d1_ff;
         e0_d2_ff <= e0_d1_ff;
      end
      if (stage_en.mul2) begin
         t3_ff    <= t2_ff;
         e0_d3_ff <= e0_d2_ff;
      end
      if (stage_en.add2) begin
         t4_ff    <= t3_ff;
         e0_d4_ff <= e0_d3_ff;
      end
   end

   cbe_horner_step #(
      .ACC_IN_WIDTH (CW),
      .T_FRAC_BITS  (T_FRAC_BITS),
      .COEF_WIDTH   (CW),
      .POWER        (1)
   ) u_step1 (
      .clock    (clock),
      .en_mul   (stage_en.mul1),
      .en_add   (stage_en.add1),
      .acc_src  (e3_ff),
      .t_src    (t0_ff),
      .coef_src (e2_ff),
      .acc_res  (acc1)
   );

   cbe_horner_step #(
      .ACC_IN_WIDTH (A1),
      .T_FRAC_BITS  (T_FRAC_BITS),
      .COEF_WIDTH   (CW),
      .POWER        (2)
   ) u_step2 (
      .clock    (clock),
      .en_mul   (stage_en.mul2),
      .en_add   (stage_en.add2),
      .acc_src  (acc1),
      .t_src    (t2_ff),
      .coef_src (e1_d2_ff),
      .acc_res  (acc2)
   );

   cbe_horner_step #(
      .ACC_IN_WIDTH (A2),
      .T_FRAC_BITS  (T_FRAC_BITS),
      .COEF_WIDTH   (CW),
      .POWER        (3)
   ) u_step3 (
      .clock    (clock),
      .en_mul   (stage_en.mul3),
      .en_add   (stage_en.add3),
      .acc_src  (acc2),
      .t_src    (t4_ff),
      .coef_src (e0_d4_ff),
      .acc_res  (acc_res)
   );

endmodule

`default_nettype wire

FILE: rtl/cbe_merge.sv
// merge stage: floor, saturate and register the three lane results
`default_nettype none

module cbe_merge import cbe_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [acc_width(COORD_WIDTH, T_FRAC_BITS, 3)-1:0] acc [NUM_AXES],
   output logic signed [OUT_WIDTH-1:0] res [NUM_AXES]
);

   localparam int AW = acc_width(COORD_WIDTH, T_FRAC_BITS, 3);
   localparam int FS = 3 * T_FRAC_BITS;
   localparam int VW = AW - FS;
   localparam int SW = (VW > OUT_WIDTH) ? VW : OUT_WIDTH;
   localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
   localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

   logic signed [SW-1:0]        val [NUM_AXES];
   logic signed [OUT_WIDTH-1:0] res_in [NUM_AXES];
   logic signed [OUT_WIDTH-1:0] res_ff [NUM_AXES];

   // dropping the fraction bits of a two's complement value floors it
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         val[a] = SW'($signed(acc[a][AW-1:FS]));
         if (val[a] > SAT_HI) begin
            res_in[a] = OUT_WIDTH'(SAT_HI);
         end else if (val[a] < SAT_LO) begin
            res_in[a] = OUT_WIDTH'(SAT_LO);
         end else begin
            res_in[a] = OUT_WIDTH'(val[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

FILE: rtl/cubic_bezier_evaluator_core.sv
// top level of the cubic bezier evaluator
`default_nettype none

// evaluates a 3d cubic bezier segment, one item per clock cycle sustained.
// each request item carries four control points (x, y, z packed low to high,
// signed q8.8), a curve parameter t in signed q2.16 and a mode; t is clamped
// to 0..1. mode 0 returns the point on the curve, mode 1 the first
// derivative with respect to t. results are exact and then floored to
// signed q12.8, saturated to 20 bits. three identical lanes, one per axis,
// rewrite the curve in power basis and run three horner steps of
// multiply-by-t, each step split into a partial-product stage and a sum
// stage; a merge stage floors, saturates and registers the three axes.
// an empty or draining stage lets the pipe keep taking items while a
// result waits, so the rate stays at one item per cycle as long as rsp
// ready is high; the pipe holds 8 items at most
module cubic_bezier_evaluator_core import cbe_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cbe_req_if.sink    req_chan,
   cbe_rsp_if.source  rsp_chan
);

   localparam int TW    = T_FRAC_BITS + 1;
   localparam int T_ONE = 1 << T_FRAC_BITS;
   localparam int AW    = acc_width(COORD_WIDTH, T_FRAC_BITS, 3);
   // points are read as if zero-extended, so coordinates past the field are zero
   localparam int PW    = (3 * COORD_WIDTH > POINT_WIDTH) ? 3 * COORD_WIDTH : POINT_WIDTH;

   logic [NUM_STAGES-1:0]          valid_ff;
   logic [NUM_STAGES-1:0]          valid_in;
   logic [NUM_STAGES-1:0]          go;
   stage_en_type                   stage_en;
   logic [TW-1:0]                  t_clamp;
   logic [PW-1:0]                  pts_ext [NUM_POINTS];
   logic signed [COORD_WIDTH-1:0]  crd [NUM_POINTS][NUM_AXES];
   logic signed [AW-1:0]           lane_acc [NUM_AXES];
   logic signed [OUT_WIDTH-1:0]    res [NUM_AXES];

   // a stage loads when it is empty or its content moves on
   always_comb begin
      go[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (!go[k]) begin
            valid_in[k] = valid_ff[k];
         end else if (k == 0) begin
            valid_in[k] = req_chan.valid;
         end else begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage enables, first stage in the highest bit
   always_comb begin
      stage_en.coef = go[0];
      stage_en.mul1 = go[1];
      stage_en.add1 = go[2];
      stage_en.mul2 = go[3];
      stage_en.add2 = go[4];
      stage_en.mul3 = go[5];
      stage_en.add3 = go[6];
      stage_en.outp = go[7];
   end

   assign req_chan.ready = go[0];
   assign rsp_chan.valid = valid_ff[NUM_STAGES-1];

   // clamp t to 0..one
   always_comb begin
      if (req_chan.param_t < 0) begin
         t_clamp = '0;
      end else if (int'(req_chan.param_t) > T_ONE) begin
         t_clamp = TW'(T_ONE);
      end else begin
         t_clamp = TW'(req_chan.param_t);
      end
   end

   // unpack coordinates, x lowest
   always_comb begin
      pts_ext[0] = PW'(req_chan.point_a);
      pts_ext[1] = PW'(req_chan.point_b);
      pts_ext[2] = PW'(req_chan.point_c);
      pts_ext[3] = PW'(req_chan.point_d);
      for (int p = 0; p < NUM_POINTS; p++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            crd[p][a] = $signed(pts_ext[p][a*COORD_WIDTH +: COORD_WIDTH]);
         end
      end
   end

   // one lane per axis
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      cbe_lane #(
         .COORD_WIDTH (COORD_WIDTH),
         .T_FRAC_BITS (T_FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .stage_en (stage_en),
         .p0       (crd[0][a]),
         .p1       (crd[1][a]),
         .p2       (crd[2][a]),
         .p3       (crd[3][a]),
         .t_val    (t_clamp),
         .mode     (req_chan.mode),
         .acc_res  (lane_acc[a])
      );
   end

   // floor, saturate and hold the result item
   cbe_merge #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_merge (
      .clock (clock),
      .en    (stage_en.outp),
      .acc   (lane_acc),
      .res   (res)
   );

   assign rsp_chan.out_x = res[0];
   assign rsp_chan.out_y = res[1];
   assign rsp_chan.out_z = res[2];

endmodule

`default_nettype wire
